// ----- sv/iee_pkg.sv -----
// Shared definitions for the infix expression evaluator.
// Holds the data path width, character codes, operator codes and the divider response type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package iee_pkg;

  // Width of the internal arithmetic. The result port always carries 32 bits.
  localparam int DATA_WIDTH = 32;
  localparam int OUT_WIDTH  = 32;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

  // Character codes that steer the parser.
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Pending multiplicative operator of the current term.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_MUL  = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  // Result of one division, valid in the cycle that done is high.
  typedef struct packed {
    logic                  done;
    logic                  div_zero;
    logic [DATA_WIDTH-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/iee_divider.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on iee_pkg for the data width and the response type.
`timescale 1ns / 1ps
`default_nettype none

module iee_divider
  import iee_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DATA_WIDTH-1:0] dividend_i,
  input  wire logic [DATA_WIDTH-1:0] divisor_i,
  output      div_rsp_t              rsp_o
);

  logic                  busy_q, busy_d;
  logic                  fin_q, fin_d;
  logic                  dz_q, dz_d;
  logic                  neg_q, neg_d;
  logic [CNT_WIDTH-1:0]  cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] den_q, den_d;

  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH:0]   rem_shift;
  logic                  fits;

  // Operand magnitudes; the most negative value keeps its bit pattern, which
  // is its correct unsigned magnitude.
  assign mag_a = dividend_i[DATA_WIDTH-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign mag_b = divisor_i[DATA_WIDTH-1]  ? (~divisor_i + 1'b1)  : divisor_i;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign rem_shift = {rem_q, quo_q[DATA_WIDTH-1]};
  assign fits      = rem_shift >= {1'b0, den_q};

  // Step sequencing.
  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    dz_d   = dz_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      neg_d = dividend_i[DATA_WIDTH-1] ^ divisor_i[DATA_WIDTH-1];
      rem_d = '0;
      den_d = mag_b;
      cnt_d = CNT_WIDTH'(DATA_WIDTH - 1);
      if (mag_b == '0) begin
        dz_d  = 1'b1;
        quo_d = '0;
        fin_d = 1'b1;
      end else begin
        dz_d   = 1'b0;
        quo_d  = mag_a;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (fits) begin
        rem_d = DATA_WIDTH'(rem_shift - {1'b0, den_q});
      end else begin
        rem_d = rem_shift[DATA_WIDTH-1:0];
      end
      quo_d = {quo_q[DATA_WIDTH-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    dz_q  <= dz_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // Apply the sign in the finishing cycle. A zero quotient stays zero.
  always_comb begin
    rsp_o.done     = fin_q;
    rsp_o.div_zero = dz_q;
    rsp_o.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;
  end

endmodule

`default_nettype wire

// ----- sv/infix_expression_evaluator.sv -----
// Top level of the infix expression evaluator: character parser, term sequencer, result register.
// Depends on iee_pkg and instantiates iee_divider.
//
// Usage:
//   The slave stream takes one ASCII character per transfer in s_axis_tdata.
//   Digits build a decimal number, spaces are skipped, + - * / combine numbers
//   with the usual precedence, and any other character ends the expression.
//   At the end the master stream offers one transfer: the 32-bit result and a
//   flag for a division by zero, after which the evaluator starts afresh.
//   A digit or a space leaves s_axis_tready high, so the next character can be
//   taken in the following cycle. An operator or end character passes through
//   S_FOLD and S_POST, with S_DIVW between them while it folds a pending
//   division in the divider, which produces one quotient bit per cycle. A multiply
//   uses a single multiplier. s_axis_tready is low while a character is being
//   worked off. The result register lets the next expression's characters be
//   taken while it waits; only a second end character stalls until the first
//   result has been transferred.
//   Reset clears all expression state and drops m_axis_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module infix_expression_evaluator
  import iee_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream. tdata: [7:0] char_code.
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  // Master stream. tdata: [31:0] value, [32] div_zero, [39:33] zero.
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FOLD = 2'd1;
  localparam logic [1:0] S_DIVW = 2'd2;
  localparam logic [1:0] S_POST = 2'd3;

  // What the accepted non-digit character asks for once the number is folded.
  localparam logic [2:0] K_MUL = 3'd0;
  localparam logic [2:0] K_DIV = 3'd1;
  localparam logic [2:0] K_ADD = 3'd2;
  localparam logic [2:0] K_SUB = 3'd3;
  localparam logic [2:0] K_END = 3'd4;

  logic [1:0]            state_q, state_d;
  logic [2:0]            kind_q, kind_d;
  logic [DATA_WIDTH-1:0] sum_q, sum_d;
  logic                  sub_q, sub_d;
  logic [DATA_WIDTH-1:0] prod_q, prod_d;
  logic [1:0]            op_q, op_d;
  logic [DATA_WIDTH-1:0] num_q, num_d;
  logic                  err_q, err_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_WIDTH-1:0]  out_value_q, out_value_d;
  logic                  out_dz_q, out_dz_d;

  logic                  accept;
  logic                  is_digit;
  logic [DATA_WIDTH-1:0] digit;
  logic [DATA_WIDTH-1:0] new_sum;
  logic [DATA_WIDTH+OUT_WIDTH-1:0] sum_ext;
  logic                  div_start;
  div_rsp_t              div_rsp;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_digit      = (s_axis_tdata >= CHAR_0) && (s_axis_tdata <= CHAR_9);
  assign digit         = DATA_WIDTH'(s_axis_tdata - CHAR_0);

  // Term applied to the running sum, and its low 32 bits zero-extended.
  assign new_sum = sub_q ? (sum_q - prod_q) : (sum_q + prod_q);
  assign sum_ext = {{OUT_WIDTH{1'b0}}, new_sum};

  iee_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (num_q),
    .rsp_o      (div_rsp)
  );

  // Sequencer and expression state update.
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    sum_d       = sum_q;
    sub_d       = sub_q;
    prod_d      = prod_q;
    op_d        = op_q;
    num_d       = num_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_value_d = out_value_q;
    out_dz_d    = out_dz_q;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_digit) begin
            num_d = (num_q << 3) + (num_q << 1) + digit;
          end else if (s_axis_tdata != CHAR_SPACE) begin
            state_d = S_FOLD;
            if (s_axis_tdata == CHAR_STAR) begin
              kind_d = K_MUL;
            end else if (s_axis_tdata == CHAR_SLASH) begin
              kind_d = K_DIV;
            end else if (s_axis_tdata == CHAR_PLUS) begin
              kind_d = K_ADD;
            end else if (s_axis_tdata == CHAR_MINUS) begin
              kind_d = K_SUB;
            end else begin
              kind_d = K_END;
            end
          end
        end
      end
      // Fold the number into the term using the pending operator.
      S_FOLD: begin
        num_d = '0;
        case (op_q)
          OP_MUL: begin
            prod_d  = DATA_WIDTH'(prod_q * num_q);
            state_d = S_POST;
          end
          OP_DIV: begin
            div_start = 1'b1;
            num_d     = num_q;
            state_d   = S_DIVW;
          end
          default: begin
            prod_d  = num_q;
            state_d = S_POST;
          end
        endcase
      end
      // Wait for the divider to finish.
      S_DIVW: begin
        if (div_rsp.done) begin
          prod_d  = div_rsp.quotient;
          num_d   = '0;
          err_d   = err_q || div_rsp.div_zero;
          state_d = S_POST;
        end
      end
      // Record the new operator, apply the term, or emit the result.
      S_POST: begin
        case (kind_q)
          K_MUL: begin
            op_d    = OP_MUL;
            state_d = S_IDLE;
          end
          K_DIV: begin
            op_d    = OP_DIV;
            state_d = S_IDLE;
          end
          K_ADD, K_SUB: begin
            sum_d   = new_sum;
            prod_d  = '0;
            op_d    = OP_NONE;
            sub_d   = (kind_q == K_SUB);
            state_d = S_IDLE;
          end
          default: begin
            if (!out_valid_q || m_axis_tready) begin
              out_valid_d = 1'b1;
              out_value_d = sum_ext[OUT_WIDTH-1:0];
              out_dz_d    = err_q;
              sum_d       = '0;
              sub_d       = 1'b0;
              prod_d      = '0;
              op_d        = OP_NONE;
              num_d       = '0;
              err_d       = 1'b0;
              state_d     = S_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and expression state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      sub_q       <= 1'b0;
      prod_q      <= '0;
      op_q        <= OP_NONE;
      num_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sub_q       <= sub_d;
      prod_q      <= prod_d;
      op_q        <= op_d;
      num_q       <= num_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    out_value_q <= out_value_d;
    out_dz_q    <= out_dz_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_dz_q, out_value_q};

endmodule

`default_nettype wire

// ----- sv/iee_checker.sv -----
// Port-level checks for the infix expression evaluator, bound to the top level.
// Depends on iee_pkg for the character codes.
`timescale 1ns / 1ps
`default_nettype none

module iee_checker
  import iee_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  logic in_xfer;
  logic in_digit;
  logic in_space;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign in_digit = (s_axis_tdata >= CHAR_0) && (s_axis_tdata <= CHAR_9);
  assign in_space = (s_axis_tdata == CHAR_SPACE);

  // Once reset has been seen at a clock edge, no result is offered.
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

  // A stalled result keeps its valid and its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // After a digit or a space the input is ready again in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_digit || in_space) |=> s_axis_tready)
    else $error("digit or space did not keep the input ready");

  // Any other character starts a fold and holds the input off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !in_digit && !in_space |=> !s_axis_tready)
    else $error("operator character did not start a fold");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/sv/infix_expression_evaluator_test.sv -----
// Self-checking testbench for infix_expression_evaluator: feeds character streams and
// compares each result transfer against an in-bench expression evaluator.
// Depends on iee_pkg and the infix_expression_evaluator RTL.
`timescale 1ns / 1ps

module infix_expression_evaluator_test;
  import iee_pkg::*;

  localparam int          DW          = DATA_WIDTH;
  localparam logic [7:0]  CHAR_EQUAL  = 8'h3D;
  localparam int          IDLE_PCT    = 27;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          MAX_REPORTS = 10;

  // One expected result transfer.
  typedef struct packed {
    logic        div_zero;
    logic [31:0] value;
  } eval_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  // Evaluator state kept by the bench.
  logic [DW-1:0] acc_sum;
  logic          sub_pending;
  logic [DW-1:0] term_value;
  logic [1:0]    term_op;
  logic [DW-1:0] num_value;
  logic          div_error;

  eval_result_t  pending_results[$];
  eval_result_t  front_result;
  int            mismatch_count = 0;
  int            chars_sent = 0;
  int            cycle_count = 0;
  bit            idle_off = 1'b0;

  infix_expression_evaluator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Run-length guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Clears the evaluator state, as the block does after each result.
  task automatic clear_evaluator();
    acc_sum     = '0;
    sub_pending = 1'b0;
    term_value  = '0;
    term_op     = OP_NONE;
    num_value   = '0;
    div_error   = 1'b0;
  endtask

  // Folds the number being read into the current term.
  task automatic fold_operand();
    logic [DW-1:0] mag_a;
    logic [DW-1:0] mag_b;
    logic [DW-1:0] quot;
    if (term_op == OP_MUL) begin
      term_value = term_value * num_value;
    end else if (term_op == OP_DIV) begin
      mag_a = term_value[DW-1] ? -term_value : term_value;
      mag_b = num_value[DW-1] ? -num_value : num_value;
      if (mag_b == '0) begin
        div_error = 1'b1;
        quot = '0;
      end else begin
        quot = mag_a / mag_b;
        if (term_value[DW-1] != num_value[DW-1]) quot = -quot;
      end
      term_value = quot;
    end else begin
      term_value = num_value;
    end
    num_value = '0;
  endtask

  // Adds or subtracts the finished term and starts a new one.
  task automatic close_term();
    if (sub_pending) acc_sum = acc_sum - term_value;
    else acc_sum = acc_sum + term_value;
    term_value = '0;
    term_op = OP_NONE;
  endtask

  // Advances the evaluator by one accepted character and queues any result.
  task automatic evaluate_char(input logic [7:0] ch);
    eval_result_t res;
    if (ch >= CHAR_0 && ch <= CHAR_9) begin
      num_value = num_value * 10 + DW'(ch - CHAR_0);
    end else if (ch == CHAR_SPACE) begin
      // Spaces are skipped.
    end else if (ch == CHAR_STAR || ch == CHAR_SLASH) begin
      fold_operand();
      term_op = (ch == CHAR_STAR) ? OP_MUL : OP_DIV;
    end else if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
      fold_operand();
      close_term();
      sub_pending = (ch == CHAR_MINUS);
    end else begin
      fold_operand();
      close_term();
      res.value    = acc_sum[31:0];
      res.div_zero = div_error;
      pending_results.push_back(res);
      clear_evaluator();
    end
  endtask

  // Sends one character with random idle cycles in front of it.
  task automatic send_char(input logic [7:0] ch);
    while (!idle_off && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    evaluate_char(ch);
    chars_sent++;
  endtask

  task automatic send_text(input string text, input logic [7:0] ending);
    foreach (text[i]) send_char(text[i]);
    send_char(ending);
  endtask

  // Picks a character that ends an expression.
  function automatic logic [7:0] pick_terminator();
    logic [7:0] ch;
    ch = 8'($urandom_range(255));
    while ((ch >= CHAR_0 && ch <= CHAR_9) || ch == CHAR_SPACE || ch == CHAR_PLUS ||
           ch == CHAR_MINUS || ch == CHAR_STAR || ch == CHAR_SLASH)
      ch = 8'($urandom_range(255));
    return ch;
  endfunction

  // Sends one mostly well-formed expression with random content.
  task automatic send_random_expression(input int noise_pct);
    int n_terms;
    int n_digits;
    int pick;
    n_terms = $urandom_range(1, 6);
    for (int t = 0; t < n_terms; t++) begin
      if ($urandom_range(9) == 0) send_char(CHAR_SPACE);
      pick = $urandom_range(99);
      if (pick < 8) n_digits = 0;
      else if (pick < 85) n_digits = $urandom_range(1, 3);
      else n_digits = $urandom_range(4, 11);
      for (int d = 0; d < n_digits; d++) send_char(CHAR_0 + 8'($urandom_range(9)));
      if ($urandom_range(9) == 0) send_char(CHAR_SPACE);
      if ($urandom_range(99) < noise_pct) send_char(8'($urandom_range(255)));
      if (t != n_terms - 1) begin
        case ($urandom_range(3))
          0: send_char(CHAR_PLUS);
          1: send_char(CHAR_MINUS);
          2: send_char(CHAR_STAR);
          default: send_char(CHAR_SLASH);
        endcase
      end
    end
    send_char(($urandom_range(99) < 80) ? CHAR_EQUAL : pick_terminator());
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Missing operands, division by zero, most negative over minus one, spaces and signs.
  task automatic test_directed();
    send_text("*/", 8'hFF);
    send_text("2147483648/4294967295", 8'h00);
    send_text("9 -8+7", CHAR_EQUAL);
  endtask

  task automatic test_random_expressions(input int char_budget);
    int stop_at;
    stop_at = chars_sent + char_budget;
    while (chars_sent < stop_at) send_random_expression(5);
  endtask

  // Results drain completely before the sender resumes.
  task automatic test_drain_pause();
    repeat (5) begin
      send_random_expression(0);
      wait_for_results();
      @(posedge clk_i);
    end
  endtask

  // A long stretch with no idle cycles on either side.
  task automatic test_steady_flow(input int char_budget);
    int stop_at;
    stop_at = chars_sent + char_budget;
    idle_off = 1'b1;
    while (chars_sent < stop_at) send_random_expression(5);
    idle_off = 1'b0;
  endtask

  // Uniform random bytes, including broken and empty expressions.
  task automatic test_noise(input int char_budget);
    repeat (char_budget) send_char(8'($urandom_range(255)));
    send_char(CHAR_EQUAL);
  endtask

  // Result checker and random backpressure on the master side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result transfer: tdata=%h", m_axis_tdata);
        end else begin
          front_result = pending_results.pop_front();
          if (m_axis_tdata[31:0] !== front_result.value ||
              m_axis_tdata[32] !== front_result.div_zero ||
              m_axis_tdata[39:33] !== 7'd0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result mismatch: expected value=%h div_zero=%b, got tdata=%h",
                       front_result.value, front_result.div_zero, m_axis_tdata);
          end
        end
      end
      m_axis_tready <= idle_off || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    clear_evaluator();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_expressions(900);
    test_drain_pause();
    test_steady_flow(300);
    test_noise(200);
    test_random_expressions(200);

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
